FILE: design/rbsi_pkg.sv
// shared types and constants of the ray box slab intersection unit
package rbsi_pkg;

   localparam int AXES = 3;

   // control that steps the pipelined slab divider
   typedef struct packed {
      logic advance;
      logic rneg;
   } rbsi_div_ctrl_type;

endpackage

FILE: design/rbsi_req_if.sv
// request channel carrying one box and one ray
interface rbsi_req_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] box_min_x;
   logic signed [COORD_WIDTH-1:0] box_min_y;
   logic signed [COORD_WIDTH-1:0] box_min_z;
   logic signed [COORD_WIDTH-1:0] box_max_x;
   logic signed [COORD_WIDTH-1:0] box_max_y;
   logic signed [COORD_WIDTH-1:0] box_max_z;
   logic signed [COORD_WIDTH-1:0] ray_origin_x;
   logic signed [COORD_WIDTH-1:0] ray_origin_y;
   logic signed [COORD_WIDTH-1:0] ray_origin_z;
   logic signed [COORD_WIDTH-1:0] ray_dir_x;
   logic signed [COORD_WIDTH-1:0] ray_dir_y;
   logic signed [COORD_WIDTH-1:0] ray_dir_z;

   modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                   box_max_z, ray_origin_x, ray_origin_y, ray_origin_z, ray_dir_x,
                   ray_dir_y, ray_dir_z, input ready);
   modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                 box_max_z, ray_origin_x, ray_origin_y, ray_origin_z, ray_dir_x,
                 ray_dir_y, ray_dir_z, output ready);
endinterface

FILE: design/rbsi_rsp_if.sv
// response channel carrying the hit flag and the entry and exit times
interface rbsi_rsp_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic signed [COORD_WIDTH-1:0] near_time;
   logic signed [COORD_WIDTH-1:0] far_time;

   modport source (output valid, hit, near_time, far_time, input ready);
   modport sink (input valid, hit, near_time, far_time, output ready);
endinterface

FILE: design/rbsi_slab_div.sv
// pipelined restoring divider giving one saturated slab crossing time
module rbsi_slab_div #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                               clock,
   input  rbsi_pkg::rbsi_div_ctrl_type        ctrl,
   input  logic [COORD_WIDTH-1:0]             mag,
   input  logic [COORD_WIDTH-1:0]             dmag,
   output logic signed [COORD_WIDTH-1:0]      time_q
);
   import rbsi_pkg::*;

   localparam int W = COORD_WIDTH;
   localparam int S = COORD_WIDTH + FRAC_BITS;
   localparam logic [W-1:0] MAX_T = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_T = {1'b1, {(W-1){1'b0}}};

   logic [W-1:0] rem_ff  [1:S];
   logic [W-1:0] q_ff    [1:S];
   logic [W-1:0] mag_ff  [1:S];
   logic [W-1:0] dmag_ff [1:S];
   logic         ov_ff   [1:S];
   logic         rneg_ff [1:S];
   logic [W-1:0] time_ff;

   // one quotient bit per stage, most significant numerator bit first
   for (genvar k = 0; k < S; k++) begin : g_stage
      localparam int  I    = S - 1 - k;
      localparam logic HIGH = (I >= W);
      logic [W-1:0] c_rem, c_q, c_mag, c_dmag;
      logic         c_ov, c_rneg, bit_v, ge;
      logic [W:0]   trial, diff;

      if (k == 0) begin : g_first
         assign c_rem  = '0;
         assign c_q    = '0;
         assign c_ov   = 1'b0;
         assign c_mag  = mag;
         assign c_dmag = dmag;
         assign c_rneg = ctrl.rneg;
      end else begin : g_next
         assign c_rem  = rem_ff[k];
         assign c_q    = q_ff[k];
         assign c_ov   = ov_ff[k];
         assign c_mag  = mag_ff[k];
         assign c_dmag = dmag_ff[k];
         assign c_rneg = rneg_ff[k];
      end

      if (I >= FRAC_BITS) begin : g_num
         assign bit_v = c_mag[I-FRAC_BITS];
      end else begin : g_frac
         assign bit_v = 1'b0;
      end

      assign trial = {c_rem, bit_v};
      assign ge    = trial >= {1'b0, c_dmag};
      assign diff  = trial - {1'b0, c_dmag};

      always_ff @(posedge clock) begin
         if (ctrl.advance) begin
            rem_ff[k+1]  <= ge ? diff[W-1:0] : trial[W-1:0];
            q_ff[k+1]    <= {c_q[W-2:0], ge};
            ov_ff[k+1]   <= c_ov | (ge & HIGH);
            mag_ff[k+1]  <= c_mag;
            dmag_ff[k+1] <= c_dmag;
            rneg_ff[k+1] <= c_rneg;
         end
      end
   end

   logic [W-1:0] lim, neg_q;
   logic         sat;
   assign lim   = rneg_ff[S] ? MIN_T : MAX_T;
   assign sat   = ov_ff[S] | (q_ff[S] > lim);
   assign neg_q = W'(-q_ff[S]);

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         if (sat) begin
            time_ff <= rneg_ff[S] ? MIN_T : MAX_T;
         end else begin
            time_ff <= rneg_ff[S] ? neg_q : q_ff[S];
         end
      end
   end

   assign time_q = time_ff;

endmodule

FILE: design/ray_box_slab_intersection_unit.sv
// top level of the ray box slab intersection unit
//
//  channel | direction | handshake     | contents
//  req     | in        | valid / ready | box bounds, ray origin and direction per axis
//  rsp     | out       | valid / ready | hit flag, near time, far time
//  csr     | in        | write enable  | require_positive_near
//
// one request enters per cycle while the output is not stalled; a request passes
// through the prep, bit-per-stage divider, ordering, reduction, output registers
// every stage moves only when the output register is empty or being taken,
// so a stall freezes the whole pipeline and nothing is lost or repeated
// reset is synchronous and clears the valid line and sets the mode bit to 1
module ray_box_slab_intersection_unit #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   rbsi_req_if.sink   req,
   rbsi_rsp_if.source rsp,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);
   import rbsi_pkg::*;

   localparam int W  = COORD_WIDTH;
   // divider depth: one stage per numerator bit plus the saturation stage
   localparam int DL = COORD_WIDTH + FRAC_BITS + 1;
   // prep, divider, ordering, reduction, output
   localparam int NV = DL + 4;
   localparam logic signed [W-1:0] MAX_T  = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MIN_T  = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] ZERO_T = '0;

   // mode register
   logic rpn_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rpn_ff <= 1'b1;
      end else if (csr_write_enable) begin
         rpn_ff <= csr_write_data;
      end
   end

   // global step: move when the output slot is free or being drained
   logic            adv, accept;
   logic [NV-1:0]   vld_ff;
   assign adv       = rsp.ready | ~vld_ff[NV-1];
   assign req.ready = adv;
   assign accept    = req.valid & adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NV-2:0], accept};
      end
   end

   // gather the request fields per axis
   logic signed [W-1:0] lo [AXES];
   logic signed [W-1:0] hi [AXES];
   logic signed [W-1:0] org [AXES];
   logic signed [W-1:0] dir [AXES];
   assign lo[0]  = req.box_min_x;
   assign lo[1]  = req.box_min_y;
   assign lo[2]  = req.box_min_z;
   assign hi[0]  = req.box_max_x;
   assign hi[1]  = req.box_max_y;
   assign hi[2]  = req.box_max_z;
   assign org[0] = req.ray_origin_x;
   assign org[1] = req.ray_origin_y;
   assign org[2] = req.ray_origin_z;
   assign dir[0] = req.ray_dir_x;
   assign dir[1] = req.ray_dir_y;
   assign dir[2] = req.ray_dir_z;

   // per-axis flags for zero direction, delayed alongside the dividers
   logic [AXES-1:0] zero_ff, inside_ff;
   logic [AXES-1:0] zl_ff [1:DL];
   logic [AXES-1:0] il_ff [1:DL];

   logic signed [W-1:0] ta [AXES];
   logic signed [W-1:0] tb [AXES];

   for (genvar a = 0; a < AXES; a++) begin : g_axis
      logic [W-1:0]      mag_lo_ff, mag_hi_ff, dmag_ff;
      logic              rneg_lo_ff, rneg_hi_ff;
      logic              nneg_lo, nneg_hi, dneg;
      logic [W:0]        d_lo, d_hi;
      rbsi_div_ctrl_type ctl_lo, ctl_hi;

      // magnitude of (bound - origin) and of the direction, and the quotient sign
      assign nneg_lo = lo[a] < org[a];
      assign nneg_hi = hi[a] < org[a];
      assign dneg    = dir[a][W-1];
      assign d_lo    = nneg_lo ? ({org[a][W-1], org[a]} - {lo[a][W-1], lo[a]})
                               : ({lo[a][W-1], lo[a]} - {org[a][W-1], org[a]});
      assign d_hi    = nneg_hi ? ({org[a][W-1], org[a]} - {hi[a][W-1], hi[a]})
                               : ({hi[a][W-1], hi[a]} - {org[a][W-1], org[a]});

      always_ff @(posedge clock) begin
         if (adv) begin
            mag_lo_ff    <= d_lo[W-1:0];
            mag_hi_ff    <= d_hi[W-1:0];
            dmag_ff      <= dneg ? W'(-dir[a]) : dir[a];
            rneg_lo_ff   <= nneg_lo ^ dneg;
            rneg_hi_ff   <= nneg_hi ^ dneg;
            zero_ff[a]   <= dir[a] == '0;
            inside_ff[a] <= !(org[a] < lo[a]) && !(hi[a] < org[a]);
         end
      end

      assign ctl_lo = '{advance: adv, rneg: rneg_lo_ff};
      assign ctl_hi = '{advance: adv, rneg: rneg_hi_ff};

      rbsi_slab_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_lo (
         .clock  (clock),
         .ctrl   (ctl_lo),
         .mag    (mag_lo_ff),
         .dmag   (dmag_ff),
         .time_q (ta[a])
      );

      rbsi_slab_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_hi (
         .clock  (clock),
         .ctrl   (ctl_hi),
         .mag    (mag_hi_ff),
         .dmag   (dmag_ff),
         .time_q (tb[a])
      );
   end

   // delay line for the zero-direction flags
   always_ff @(posedge clock) begin
      if (adv) begin
         zl_ff[1] <= zero_ff;
         il_ff[1] <= inside_ff;
         for (int i = 2; i <= DL; i++) begin
            zl_ff[i] <= zl_ff[i-1];
            il_ff[i] <= il_ff[i-1];
         end
      end
   end

   // order the two crossing times, or substitute the zero-direction interval
   logic signed [W-1:0] t0_ff [AXES];
   logic signed [W-1:0] t1_ff [AXES];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < AXES; a++) begin
            if (zl_ff[DL][a]) begin
               t0_ff[a] <= il_ff[DL][a] ? MIN_T : MAX_T;
               t1_ff[a] <= il_ff[DL][a] ? MAX_T : MIN_T;
            end else begin
               t0_ff[a] <= (tb[a] < ta[a]) ? tb[a] : ta[a];
               t1_ff[a] <= (tb[a] < ta[a]) ? ta[a] : tb[a];
            end
         end
      end
   end

   // near is the largest entry time, far the smallest exit time
   logic signed [W-1:0] near_in, far_in, near_ff, far_ff;
   always_comb begin
      near_in = MIN_T;
      far_in  = MAX_T;
      for (int a = 0; a < AXES; a++) begin
         if (near_in < t0_ff[a]) begin
            near_in = t0_ff[a];
         end
         if (t1_ff[a] < far_in) begin
            far_in = t1_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         near_ff <= near_in;
         far_ff  <= far_in;
      end
   end

   // output register with the hit decision, signed compare against zero
   logic                hit_in, hit_ff;
   logic signed [W-1:0] nt_ff, ft_ff;
   assign hit_in = (near_ff < far_ff) && !(rpn_ff && !(near_ff > ZERO_T));

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= hit_in;
         nt_ff  <= near_ff;
         ft_ff  <= far_ff;
      end
   end

   assign rsp.valid     = vld_ff[NV-1];
   assign rsp.hit       = hit_ff;
   assign rsp.near_time = nt_ff;
   assign rsp.far_time  = ft_ff;

   // a hit always means the interval is not empty
   a_hit_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.hit |-> rsp.near_time < rsp.far_time)
      else $error("hit reported with near time not below far time");

   // a stall freezes the whole valid line
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

   // an accepted request enters the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");

   // nothing is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("response valid after reset");

endmodule

FILE: verif/rbsi_checker.sv
// checker for the ray box slab intersection unit: predicts and compares responses
module rbsi_checker #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic     clock,
   input  logic     reset,
   rbsi_req_if.sink req,
   rbsi_rsp_if.sink rsp,
   input  logic     csr_write_enable,
   input  logic     csr_write_data,
   output int       fail_count,
   output int       pending
);
   import rbsi_pkg::*;

   localparam logic signed [COORD_WIDTH-1:0] TMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] TMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic                          hit;
      logic signed [COORD_WIDTH-1:0] near_t;
      logic signed [COORD_WIDTH-1:0] far_t;
   } slab_result_t;

   slab_result_t expected_hits[$];
   logic         positive_near;

   // exact quotient, truncated toward zero, saturated to the coordinate range
   function automatic logic signed [COORD_WIDTH-1:0] crossing_time(
      logic signed [COORD_WIDTH-1:0] bound, logic signed [COORD_WIDTH-1:0] orig,
      logic signed [COORD_WIDTH-1:0] dir);
      logic signed [2*COORD_WIDTH+FRAC_BITS+1:0] num, den, quo;
      num = (2*COORD_WIDTH+FRAC_BITS+2)'(bound) - (2*COORD_WIDTH+FRAC_BITS+2)'(orig);
      num = num <<< FRAC_BITS;
      den = (2*COORD_WIDTH+FRAC_BITS+2)'(dir);
      quo = num / den;
      if (quo > TMAX) return TMAX;
      if (quo < TMIN) return TMIN;
      return quo[COORD_WIDTH-1:0];
   endfunction

   function automatic slab_result_t slab_test(logic signed [COORD_WIDTH-1:0] lo[3],
      logic signed [COORD_WIDTH-1:0] hi[3], logic signed [COORD_WIDTH-1:0] org[3],
      logic signed [COORD_WIDTH-1:0] dir[3], logic pos);
      slab_result_t r;
      logic signed [COORD_WIDTH-1:0] t0, t1, ta, tb;
      r.near_t = TMIN;
      r.far_t  = TMAX;
      for (int a = 0; a < AXES; a++) begin
         if (dir[a] == 0) begin
            if (org[a] >= lo[a] && org[a] <= hi[a]) begin
               t0 = TMIN; t1 = TMAX;
            end else begin
               t0 = TMAX; t1 = TMIN;
            end
         end else begin
            ta = crossing_time(lo[a], org[a], dir[a]);
            tb = crossing_time(hi[a], org[a], dir[a]);
            t0 = (tb < ta) ? tb : ta;
            t1 = (tb < ta) ? ta : tb;
         end
         if (t0 > r.near_t) r.near_t = t0;
         if (t1 < r.far_t) r.far_t = t1;
      end
      r.hit = (r.near_t < r.far_t) && (!pos || r.near_t > 0);
      return r;
   endfunction

   assign pending = expected_hits.size();

   always @(posedge clock) begin
      slab_result_t exp_r, got;
      logic signed [COORD_WIDTH-1:0] lo[3], hi[3], org[3], dir[3];
      if (reset) begin
         positive_near <= 1'b1;
         fail_count    <= 0;
         expected_hits.delete();
      end else begin
         if (req.valid && req.ready) begin
            lo  = '{req.box_min_x, req.box_min_y, req.box_min_z};
            hi  = '{req.box_max_x, req.box_max_y, req.box_max_z};
            org = '{req.ray_origin_x, req.ray_origin_y, req.ray_origin_z};
            dir = '{req.ray_dir_x, req.ray_dir_y, req.ray_dir_z};
            expected_hits.push_back(slab_test(lo, hi, org, dir, positive_near));
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.hit, rsp.near_time, rsp.far_time};
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_hits.pop_front();
               if (got.hit !== exp_r.hit || got.near_t !== exp_r.near_t
                   || got.far_t !== exp_r.far_t) begin
                  $display("%0t: expected hit %b near %h far %h, got hit %b near %h far %h",
                           $time, exp_r.hit, exp_r.near_t, exp_r.far_t,
                           got.hit, got.near_t, got.far_t);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_write_enable) positive_near <= csr_write_data;
      end
   end
endmodule

FILE: verif/tb_top.sv
// testbench top of the ray box slab intersection unit: stimulus and verdict
module tb_top;
   localparam int CW      = 32;
   localparam int FB      = 16;
   localparam int LATENCY = CW + FB + 5;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_write_data   = 1'b0;
   int   fail_count;
   int   pending;
   int   send_idle_pct;
   int   recv_idle_pct;

   rbsi_req_if #(.COORD_WIDTH(CW)) req_ch ();
   rbsi_rsp_if #(.COORD_WIDTH(CW)) rsp_ch ();

   ray_box_slab_intersection_unit #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch.sink),
      .rsp              (rsp_ch.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   rbsi_checker #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch.sink),
      .rsp              (rsp_ch.sink),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   always #10 clock = ~clock;

   // request fields in port order: min xyz, max xyz, origin xyz, direction xyz
   typedef logic signed [CW-1:0] ray_box_t [12];

   initial begin
      req_ch.valid = 1'b0;
      {req_ch.box_min_x, req_ch.box_min_y, req_ch.box_min_z} = '0;
      {req_ch.box_max_x, req_ch.box_max_y, req_ch.box_max_z} = '0;
      {req_ch.ray_origin_x, req_ch.ray_origin_y, req_ch.ray_origin_z} = '0;
      {req_ch.ray_dir_x, req_ch.ray_dir_y, req_ch.ray_dir_z} = '0;
      rsp_ch.ready = 1'b0;
   end

   // receiver stalls at the rate of the current phase
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // one request: idle first at random with valid low, then hold valid until taken;
   // valid stays high on return so the next request can follow with no gap
   task automatic send_request(ray_box_t f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.box_min_x    <= f[0];  req_ch.box_min_y    <= f[1];  req_ch.box_min_z    <= f[2];
      req_ch.box_max_x    <= f[3];  req_ch.box_max_y    <= f[4];  req_ch.box_max_z    <= f[5];
      req_ch.ray_origin_x <= f[6];  req_ch.ray_origin_y <= f[7];  req_ch.ray_origin_z <= f[8];
      req_ch.ray_dir_x    <= f[9];  req_ch.ray_dir_y    <= f[10]; req_ch.ray_dir_z    <= f[11];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // the unit must be drained before the mode bit changes
   task automatic write_mode(logic v);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // random coordinate: mostly small Q16.16 values, sometimes full range or extremes
   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(9))
         0:       return $urandom;
         1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         2:       return 0;
         3:       return $signed($urandom_range(8)) - 4;
         default: return $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
      endcase
   endfunction

   // mostly sensible boxes around the origin, sometimes swapped or degenerate
   function automatic ray_box_t rand_ray_box();
      ray_box_t f;
      logic signed [CW-1:0] t;
      for (int a = 0; a < 3; a++) begin
         f[a]     = rand_coord();
         f[3 + a] = rand_coord();
         if ($urandom_range(9) < 8 && f[a] > f[3 + a]) begin
            t = f[a]; f[a] = f[3 + a]; f[3 + a] = t;
         end
         f[6 + a] = ($urandom_range(4) == 0) ? f[a + 3 * $urandom_range(1)] : rand_coord();
         f[9 + a] = ($urandom_range(7) == 0) ? 0 : rand_coord();
      end
      return f;
   endfunction

   task automatic run_phase(int n, int s_idle, int r_idle);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (int i = 0; i < n; i++) send_request(rand_ray_box());
   endtask

   localparam logic signed [CW-1:0] ONE  = 32'sh0001_0000;
   localparam logic signed [CW-1:0] PMAX = 32'sh7fffffff;
   localparam logic signed [CW-1:0] NMIN = 32'sh80000000;

   initial begin
      ray_box_t f;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unit box, ray from -2 along +x, with the mode bit at reset value
      send_request('{-ONE, -ONE, -ONE, ONE, ONE, ONE, -2 * ONE, 0, 0, ONE, 0, 0});
      // origin inside, so near is negative and no hit while near must be positive
      send_request('{-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE});
      // zero direction outside the slab gives the empty interval
      send_request('{-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 2 * ONE, 0, ONE, 0, 0});
      // zero direction on the slab boundary counts as inside
      send_request('{-ONE, -ONE, -ONE, ONE, ONE, ONE, -2 * ONE, ONE, -ONE, ONE, 0, 0});
      // swapped bounds, and zero direction with a swapped box
      send_request('{ONE, ONE, ONE, -ONE, -ONE, -ONE, -2 * ONE, -2 * ONE, -2 * ONE,
                     ONE, ONE, ONE});
      send_request('{ONE, -ONE, -ONE, -ONE, ONE, ONE, 0, 0, 0, 0, ONE, ONE});
      // negative directions and saturation at both ends
      send_request('{-ONE, -ONE, -ONE, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE,
                     -ONE, -ONE, -ONE});
      send_request('{NMIN, NMIN, NMIN, PMAX, PMAX, PMAX, 0, 0, 0, 1, -1, 1});
      send_request('{NMIN, NMIN, NMIN, PMAX, PMAX, PMAX, PMAX, NMIN, PMAX, NMIN, PMAX, -1});
      send_request('{PMAX, NMIN, PMAX, NMIN, PMAX, NMIN, NMIN, PMAX, NMIN, PMAX, NMIN, PMAX});
      send_request('{NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, 0, 0, 0});
      send_request('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1});
      write_mode(1'b0);
      send_request('{-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE});
      send_request('{-ONE, -ONE, -ONE, ONE, ONE, ONE, 2 * ONE, 0, 0, ONE, 0, 0});
      send_request('{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 0, 0, 0});

      // random phases: receiver idles more, then sender idles more, twice over, then neither
      run_phase(300, 31, 87);
      write_mode(1'b1);
      run_phase(300, 87, 31);
      write_mode(1'b0);
      run_phase(300, 31, 87);
      write_mode(1'b1);
      run_phase(300, 87, 31);
      run_phase(550, 0, 0);
      req_ch.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   // watchdog well above the slowest correct run
   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end
endmodule
